### hdl/etmm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the model matrix builder.
// Used by etmm_front, etmm_trig, etmm_back and the top level; depends on nothing.

package etmm_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int TRIG_ITER_DEF  = 16;
    localparam int ATAN_SLOTS     = 30;
    localparam int QUAD_BITS      = 40;
    localparam int SERIES_BITS    = 44;
    localparam longint unsigned PI_SERIES = 64'h3243F6A8885A;

    localparam int OPW = 33;
    localparam logic signed [OPW-1:0] GAIN_Q30 = 33'sh026DD3B6A;
    localparam logic signed [OPW-1:0] ONE_Q30  = 33'sh040000000;

    localparam logic [1:0] TMODE_NONE   = 2'd0;
    localparam logic [1:0] TMODE_LOCAL  = 2'd1;
    localparam logic [1:0] TMODE_GLOBAL = 2'd2;

    typedef enum logic [1:0] {TX_NONE, TX_LOCAL, TX_GLOBAL} tx_kind_t;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        tx_kind_t           kind;
        logic               rot;
    } item_t;

    typedef struct packed {
        logic                  done;
        logic signed [OPW-1:0] cos;
        logic signed [OPW-1:0] sin;
    } trig_res_t;

    typedef logic [QUAD_BITS:0] atan_t;
    typedef atan_t atan_tab_t [ATAN_SLOTS];

    typedef enum logic [5:0] {
        OP_CA, OP_SA, OP_CB, OP_SB, OP_CZ, OP_SZ, OP_ONE, OP_SASB, OP_CASB,
        OP_R00, OP_R01, OP_R02, OP_R10, OP_R11, OP_R12, OP_R20, OP_R21, OP_R22,
        OP_M00, OP_M01, OP_M02, OP_M10, OP_M11, OP_M12, OP_M20, OP_M21, OP_M22,
        OP_TX, OP_TY, OP_TZ, OP_SCL_X, OP_SCL_Y, OP_SCL_Z
    } opd_t;

    typedef enum logic [4:0] {
        DS_NONE, DS_SASB, DS_CASB,
        DS_R00, DS_R01, DS_R02, DS_R10, DS_R11, DS_R12, DS_R20, DS_R21, DS_R22,
        DS_M00, DS_M01, DS_M02, DS_M10, DS_M11, DS_M12, DS_M20, DS_M21, DS_M22,
        DS_C30, DS_C31, DS_C32
    } dst_t;

    typedef struct packed {
        opd_t a;
        opd_t b;
        logic sh30;
        logic neg;
        logic clr;
        dst_t dst;
    } step_t;

    localparam int NSTEPS = 33;

    function automatic step_t mk(input opd_t a, input opd_t b, input logic sh30,
                                 input logic neg, input logic clr, input dst_t dst);
        step_t s;
        s.a = a;
        s.b = b;
        s.sh30 = sh30;
        s.neg = neg;
        s.clr = clr;
        s.dst = dst;
        return s;
    endfunction

    // Product sequence: rotation terms, then scaling, then the local translation column.
    function automatic step_t prog_step(input logic [5:0] idx);
        step_t s;
        unique case (idx)
            6'd0:  s = mk(OP_SA,   OP_SB,    1'b1, 1'b0, 1'b1, DS_SASB);
            6'd1:  s = mk(OP_CA,   OP_SB,    1'b1, 1'b0, 1'b1, DS_CASB);
            6'd2:  s = mk(OP_CB,   OP_CZ,    1'b1, 1'b0, 1'b1, DS_R00);
            6'd3:  s = mk(OP_CB,   OP_SZ,    1'b1, 1'b0, 1'b1, DS_R01);
            6'd4:  s = mk(OP_SB,   OP_ONE,   1'b1, 1'b0, 1'b1, DS_R02);
            6'd5:  s = mk(OP_SASB, OP_CZ,    1'b1, 1'b0, 1'b1, DS_NONE);
            6'd6:  s = mk(OP_CA,   OP_SZ,    1'b1, 1'b1, 1'b0, DS_R10);
            6'd7:  s = mk(OP_SASB, OP_SZ,    1'b1, 1'b0, 1'b1, DS_NONE);
            6'd8:  s = mk(OP_CA,   OP_CZ,    1'b1, 1'b0, 1'b0, DS_R11);
            6'd9:  s = mk(OP_SA,   OP_CB,    1'b1, 1'b1, 1'b1, DS_R12);
            6'd10: s = mk(OP_CASB, OP_CZ,    1'b1, 1'b1, 1'b1, DS_NONE);
            6'd11: s = mk(OP_SA,   OP_SZ,    1'b1, 1'b1, 1'b0, DS_R20);
            6'd12: s = mk(OP_CASB, OP_SZ,    1'b1, 1'b1, 1'b1, DS_NONE);
            6'd13: s = mk(OP_SA,   OP_CZ,    1'b1, 1'b0, 1'b0, DS_R21);
            6'd14: s = mk(OP_CA,   OP_CB,    1'b1, 1'b0, 1'b1, DS_R22);
            6'd15: s = mk(OP_R00,  OP_SCL_X, 1'b1, 1'b0, 1'b1, DS_M00);
            6'd16: s = mk(OP_R01,  OP_SCL_Y, 1'b1, 1'b0, 1'b1, DS_M01);
            6'd17: s = mk(OP_R02,  OP_SCL_Z, 1'b1, 1'b0, 1'b1, DS_M02);
            6'd18: s = mk(OP_R10,  OP_SCL_X, 1'b1, 1'b0, 1'b1, DS_M10);
            6'd19: s = mk(OP_R11,  OP_SCL_Y, 1'b1, 1'b0, 1'b1, DS_M11);
            6'd20: s = mk(OP_R12,  OP_SCL_Z, 1'b1, 1'b0, 1'b1, DS_M12);
            6'd21: s = mk(OP_R20,  OP_SCL_X, 1'b1, 1'b0, 1'b1, DS_M20);
            6'd22: s = mk(OP_R21,  OP_SCL_Y, 1'b1, 1'b0, 1'b1, DS_M21);
            6'd23: s = mk(OP_R22,  OP_SCL_Z, 1'b1, 1'b0, 1'b1, DS_M22);
            6'd24: s = mk(OP_M00,  OP_TX,    1'b0, 1'b0, 1'b1, DS_NONE);
            6'd25: s = mk(OP_M01,  OP_TY,    1'b0, 1'b0, 1'b0, DS_NONE);
            6'd26: s = mk(OP_M02,  OP_TZ,    1'b0, 1'b0, 1'b0, DS_C30);
            6'd27: s = mk(OP_M10,  OP_TX,    1'b0, 1'b0, 1'b1, DS_NONE);
            6'd28: s = mk(OP_M11,  OP_TY,    1'b0, 1'b0, 1'b0, DS_NONE);
            6'd29: s = mk(OP_M12,  OP_TZ,    1'b0, 1'b0, 1'b0, DS_C31);
            6'd30: s = mk(OP_M20,  OP_TX,    1'b0, 1'b0, 1'b1, DS_NONE);
            6'd31: s = mk(OP_M21,  OP_TY,    1'b0, 1'b0, 1'b0, DS_NONE);
            6'd32: s = mk(OP_M22,  OP_TZ,    1'b0, 1'b0, 1'b0, DS_C32);
            default: s = mk(OP_ONE, OP_ONE,  1'b1, 1'b0, 1'b1, DS_NONE);
        endcase
        return s;
    endfunction

    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            r = (r << 1) | ((num >> k) & 64'd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'd1 << k);
            end
        end
        return q;
    endfunction

    // Arctangent table in units of 2^40 per quarter turn, from the power series.
    function automatic atan_tab_t build_atan();
        atan_tab_t tab;
        longint sum;
        longint unsigned term;
        longint unsigned num;
        longint unsigned q;
        int e;
        tab[0] = atan_t'(64'd1 << (QUAD_BITS - 1));
        for (int i = 1; i < ATAN_SLOTS; i++) begin
            sum = 0;
            for (int k = 0; k < 23; k++) begin
                e = i * (2 * k + 1);
                if (e <= SERIES_BITS) begin
                    term = udiv(64'd1 << (SERIES_BITS - e), longint'(2 * k + 1));
                    if ((k & 1) == 1) begin
                        sum = sum - longint'(term);
                    end else begin
                        sum = sum + longint'(term);
                    end
                end
            end
            num = longint'(sum);
            q = 0;
            for (int b = 0; b < QUAD_BITS + 1; b++) begin
                num = num << 1;
                q = q << 1;
                if (num >= PI_SERIES) begin
                    num = num - PI_SERIES;
                    q = q | 64'd1;
                end
            end
            tab[i] = atan_t'(q);
        end
        return tab;
    endfunction

endpackage

### hdl/etmm_front.sv
`timescale 1ns / 1ps
// Front end: accepts request words, decodes the modes and the effective scale,
// and holds them in a two-entry queue for the back end. Depends on etmm_pkg.

module etmm_front #(
    parameter int FRAC_BITS = etmm_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_trans_x,
    input  logic signed [31:0]  s_trans_y,
    input  logic signed [31:0]  s_trans_z,
    input  logic signed [31:0]  s_angle_x,
    input  logic signed [31:0]  s_angle_y,
    input  logic signed [31:0]  s_angle_z,
    input  logic signed [31:0]  s_scale_x,
    input  logic signed [31:0]  s_scale_y,
    input  logic signed [31:0]  s_scale_z,
    input  logic [1:0]          s_translate_mode,
    input  logic                s_rotate_enable,
    input  logic                s_scale_enable,
    output logic                q_valid,
    input  logic                q_pop,
    output etmm_pkg::item_t     q_item
);

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

    etmm_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    etmm_pkg::item_t cls;
    logic            push;

    always_comb begin
        cls.tx  = s_trans_x;
        cls.ty  = s_trans_y;
        cls.tz  = s_trans_z;
        cls.ax  = s_angle_x;
        cls.ay  = s_angle_y;
        cls.az  = s_angle_z;
        cls.sx  = s_scale_enable ? s_scale_x : ONE_FX;
        cls.sy  = s_scale_enable ? s_scale_y : ONE_FX;
        cls.sz  = s_scale_enable ? s_scale_z : ONE_FX;
        cls.rot = s_rotate_enable;
        unique case (s_translate_mode)
            etmm_pkg::TMODE_LOCAL:  cls.kind = etmm_pkg::TX_LOCAL;
            etmm_pkg::TMODE_GLOBAL: cls.kind = etmm_pkg::TX_GLOBAL;
            default:                cls.kind = etmm_pkg::TX_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hdl/etmm_trig.sv
`timescale 1ns / 1ps
// Sine and cosine of an angle in degrees: quadrant split and scaling by 1/90 through
// reciprocal multiplication, then a rotation-mode CORDIC, one step a cycle. Depends on etmm_pkg.

module etmm_trig #(
    parameter int FRAC_BITS       = etmm_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = etmm_pkg::TRIG_ITER_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [31:0]   angle,
    output etmm_pkg::trig_res_t  res
);

    // The whole-degree part is offset by a multiple of 360 so that it is never negative.
    localparam int HW  = 9 + 31 - FRAC_BITS;
    localparam int QW  = HW - 6;
    localparam int SQ  = HW + 7;
    localparam int RMW = FRAC_BITS + 7;
    localparam int PLW = RMW + 24;
    localparam int SW  = RMW + 48;
    localparam int TZ  = FRAC_BITS + 14;
    localparam int ZW  = etmm_pkg::QUAD_BITS + 3;
    localparam int OPW = etmm_pkg::OPW;
    localparam int NIT = (TRIG_ITERATIONS > etmm_pkg::ATAN_SLOTS) ?
                         etmm_pkg::ATAN_SLOTS : TRIG_ITERATIONS;
    localparam logic signed [HW:0] OFF = (HW + 1)'(360) << (31 - FRAC_BITS);
    localparam logic [HW:0] MQ = (HW + 1)'(((64'd1 << SQ) + 64'd89) / 64'd90);
    localparam logic [47:0] MZ = 48'(((64'd1 << (etmm_pkg::QUAD_BITS + 14)) + 64'd89) / 64'd90);
    localparam logic [23:0] MZ_LO = MZ[23:0];
    localparam logic [23:0] MZ_HI = MZ[47:24];
    localparam etmm_pkg::atan_tab_t ATAN = etmm_pkg::build_atan();

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_QUO  = 3'd1;
    localparam logic [2:0] T_REM  = 3'd2;
    localparam logic [2:0] T_MUL  = 3'd3;
    localparam logic [2:0] T_SUM  = 3'd4;
    localparam logic [2:0] T_ROT  = 3'd5;
    localparam logic [2:0] T_MAP  = 3'd6;
    localparam logic [2:0] T_DONE = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [HW-1:0]         hq_reg, hq_next;
    logic [FRAC_BITS-1:0]  fr_reg, fr_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [RMW-1:0]        rem_reg, rem_next;
    logic [PLW-1:0]        plo_reg, plo_next;
    logic [PLW-1:0]        phi_reg, phi_next;
    logic [1:0]            quad_reg, quad_next;
    logic signed [OPW-1:0] x_reg, x_next;
    logic signed [OPW-1:0] y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic signed [OPW-1:0] cos_reg, cos_next;
    logic signed [OPW-1:0] sin_reg, sin_next;
    logic signed [HW:0]    hsum;
    logic [2*HW:0]         qprod;
    logic [6:0]            k;
    logic [SW-1:0]         zsum;
    logic signed [OPW-1:0] xs, ys;
    logic signed [ZW-1:0]  atz;

    assign hsum  = $signed({{9{angle[31]}}, angle[31:FRAC_BITS]}) + OFF;
    assign qprod = (2 * HW + 1)'(hq_reg) * (2 * HW + 1)'(MQ);
    assign k     = 7'(hq_reg - HW'(q_reg) * HW'(90));
    assign zsum  = (SW'(phi_reg) << 24) + SW'(plo_reg);
    assign xs    = x_reg >>> cnt_reg;
    assign ys    = y_reg >>> cnt_reg;
    assign atz   = $signed({2'b00, ATAN[cnt_reg]});

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hq_next    = hq_reg;
        fr_next    = fr_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        quad_next  = quad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        unique case (state_reg)
            T_IDLE, T_DONE: begin
                if (start) begin
                    hq_next    = hsum[HW-1:0];
                    fr_next    = angle[FRAC_BITS-1:0];
                    state_next = T_QUO;
                end
            end
            T_QUO: begin
                q_next     = qprod[2*HW:SQ];
                state_next = T_REM;
            end
            T_REM: begin
                rem_next   = {k, fr_reg};
                quad_next  = q_reg[1:0];
                state_next = T_MUL;
            end
            T_MUL: begin
                plo_next   = PLW'(rem_reg) * PLW'(MZ_LO);
                phi_next   = PLW'(rem_reg) * PLW'(MZ_HI);
                state_next = T_SUM;
            end
            T_SUM: begin
                z_next     = {3'b000, zsum[TZ +: etmm_pkg::QUAD_BITS]};
                x_next     = etmm_pkg::GAIN_Q30;
                y_next     = '0;
                cnt_next   = 5'd0;
                state_next = T_ROT;
            end
            T_ROT: begin
                if (!z_reg[ZW-1]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atz;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atz;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(NIT - 1)) begin
                    state_next = T_MAP;
                end
            end
            T_MAP: begin
                unique case (quad_reg)
                    2'd0: begin cos_next = x_reg;  sin_next = y_reg;  end
                    2'd1: begin cos_next = -y_reg; sin_next = x_reg;  end
                    2'd2: begin cos_next = -x_reg; sin_next = -y_reg; end
                    default: begin cos_next = y_reg; sin_next = -x_reg; end
                endcase
                state_next = T_DONE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        hq_reg   <= hq_next;
        fr_reg   <= fr_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        quad_reg <= quad_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign res.done = (state_reg == T_DONE);
    assign res.cos  = cos_reg;
    assign res.sin  = sin_reg;

endmodule

### hdl/etmm_back.sv
`timescale 1ns / 1ps
// Back end: three trig units, a shared multiply-accumulate sequencer for the matrix
// and the column output register. Depends on etmm_pkg and etmm_trig.

module etmm_back #(
    parameter int FRAC_BITS       = etmm_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = etmm_pkg::TRIG_ITER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  etmm_pkg::item_t    q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_column_index,
    output logic signed [31:0] m_row0,
    output logic signed [31:0] m_row1,
    output logic signed [31:0] m_row2,
    output logic signed [31:0] m_row3,
    output logic               m_last_column
);

    localparam int OPW  = etmm_pkg::OPW;
    localparam int PW   = 2 * OPW;
    localparam int ACCW = 66 - FRAC_BITS;
    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [PW:0] RND30  = (PW + 1)'(1) <<< 29;
    localparam logic signed [PW:0] RNDFX  = (PW + 1)'(1) <<< (FRAC_BITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TRIG = 2'd1;
    localparam logic [1:0] ST_MAC  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [5:0]             step_reg, step_next;
    logic                   phase_reg;
    logic [1:0]             col_reg;
    logic                   m_valid_reg;
    etmm_pkg::item_t        item_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic signed [OPW-1:0]  ca_reg, sa_reg, cb_reg, sb_reg, cz_reg, sz_reg;
    logic signed [OPW-1:0]  sasb_reg, casb_reg;
    logic signed [OPW-1:0]  r_reg [9];
    logic signed [31:0]     m_reg [9];
    logic signed [31:0]     c3_reg [3];

    etmm_pkg::trig_res_t    tr_x, tr_y, tr_z;
    etmm_pkg::step_t        st;
    etmm_pkg::opd_t         sel [2];
    logic signed [OPW-1:0]  v [2];
    logic signed [PW:0]     rsum;
    logic signed [PW:0]     shifted;
    logic signed [ACCW-1:0] term;
    logic signed [31:0]     acc_sat;
    logic                   trig_start;
    logic                   all_done;
    logic                   out_fire;

    assign trig_start = (state_reg == ST_IDLE) && q_valid;
    assign q_pop      = trig_start;
    assign all_done   = tr_x.done && tr_y.done && tr_z.done;
    assign out_fire   = m_valid_reg && m_ready;

    etmm_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_x (
        .aclk(aclk), .aresetn(aresetn), .start(trig_start), .angle(q_item.ax), .res(tr_x)
    );
    etmm_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_y (
        .aclk(aclk), .aresetn(aresetn), .start(trig_start), .angle(q_item.ay), .res(tr_y)
    );
    etmm_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_z (
        .aclk(aclk), .aresetn(aresetn), .start(trig_start), .angle(q_item.az), .res(tr_z)
    );

    assign st     = etmm_pkg::prog_step(step_reg);
    assign sel[0] = st.a;
    assign sel[1] = st.b;

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            unique case (sel[p])
                etmm_pkg::OP_CA:    v[p] = ca_reg;
                etmm_pkg::OP_SA:    v[p] = sa_reg;
                etmm_pkg::OP_CB:    v[p] = cb_reg;
                etmm_pkg::OP_SB:    v[p] = sb_reg;
                etmm_pkg::OP_CZ:    v[p] = cz_reg;
                etmm_pkg::OP_SZ:    v[p] = sz_reg;
                etmm_pkg::OP_ONE:   v[p] = etmm_pkg::ONE_Q30;
                etmm_pkg::OP_SASB:  v[p] = sasb_reg;
                etmm_pkg::OP_CASB:  v[p] = casb_reg;
                etmm_pkg::OP_R00:   v[p] = r_reg[0];
                etmm_pkg::OP_R01:   v[p] = r_reg[1];
                etmm_pkg::OP_R02:   v[p] = r_reg[2];
                etmm_pkg::OP_R10:   v[p] = r_reg[3];
                etmm_pkg::OP_R11:   v[p] = r_reg[4];
                etmm_pkg::OP_R12:   v[p] = r_reg[5];
                etmm_pkg::OP_R20:   v[p] = r_reg[6];
                etmm_pkg::OP_R21:   v[p] = r_reg[7];
                etmm_pkg::OP_R22:   v[p] = r_reg[8];
                etmm_pkg::OP_M00:   v[p] = OPW'(m_reg[0]);
                etmm_pkg::OP_M01:   v[p] = OPW'(m_reg[1]);
                etmm_pkg::OP_M02:   v[p] = OPW'(m_reg[2]);
                etmm_pkg::OP_M10:   v[p] = OPW'(m_reg[3]);
                etmm_pkg::OP_M11:   v[p] = OPW'(m_reg[4]);
                etmm_pkg::OP_M12:   v[p] = OPW'(m_reg[5]);
                etmm_pkg::OP_M20:   v[p] = OPW'(m_reg[6]);
                etmm_pkg::OP_M21:   v[p] = OPW'(m_reg[7]);
                etmm_pkg::OP_M22:   v[p] = OPW'(m_reg[8]);
                etmm_pkg::OP_TX:    v[p] = OPW'(item_reg.tx);
                etmm_pkg::OP_TY:    v[p] = OPW'(item_reg.ty);
                etmm_pkg::OP_TZ:    v[p] = OPW'(item_reg.tz);
                etmm_pkg::OP_SCL_X: v[p] = OPW'(item_reg.sx);
                etmm_pkg::OP_SCL_Y: v[p] = OPW'(item_reg.sy);
                etmm_pkg::OP_SCL_Z: v[p] = OPW'(item_reg.sz);
                default:            v[p] = '0;
            endcase
        end
    end

    always_comb begin
        rsum     = {prod_reg[PW-1], prod_reg} + (st.sh30 ? RND30 : RNDFX);
        shifted  = st.sh30 ? (rsum >>> 30) : (rsum >>> FRAC_BITS);
        term     = shifted[ACCW-1:0];
        acc_next = (st.clr ? '0 : acc_reg) + (st.neg ? -term : term);
        if ((&acc_next[ACCW-1:31]) || !(|acc_next[ACCW-1:31])) begin
            acc_sat = acc_next[31:0];
        end else begin
            acc_sat = acc_next[ACCW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: begin
                if (all_done) begin
                    step_next  = 6'd0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (phase_reg) begin
                    step_next = step_reg + 6'd1;
                    if (step_reg == 6'(etmm_pkg::NSTEPS - 1)) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            default: begin
                if (out_fire && (col_reg == 2'd3)) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= 6'd0;
            phase_reg   <= 1'b0;
            col_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= (state_reg == ST_MAC) ? ~phase_reg : 1'b0;
            if ((state_reg == ST_MAC) && phase_reg &&
                (step_reg == 6'(etmm_pkg::NSTEPS - 1))) begin
                m_valid_reg <= 1'b1;
                col_reg     <= 2'd0;
            end else if (out_fire) begin
                col_reg <= col_reg + 2'd1;
                if (col_reg == 2'd3) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (trig_start) begin
            item_reg <= q_item;
        end
        if ((state_reg == ST_TRIG) && all_done) begin
            ca_reg <= item_reg.rot ? tr_x.cos : etmm_pkg::ONE_Q30;
            sa_reg <= item_reg.rot ? tr_x.sin : '0;
            cb_reg <= item_reg.rot ? tr_y.cos : etmm_pkg::ONE_Q30;
            sb_reg <= item_reg.rot ? tr_y.sin : '0;
            cz_reg <= item_reg.rot ? tr_z.cos : etmm_pkg::ONE_Q30;
            sz_reg <= item_reg.rot ? tr_z.sin : '0;
        end
        if ((state_reg == ST_MAC) && !phase_reg) begin
            prod_reg <= v[0] * v[1];
        end
        if ((state_reg == ST_MAC) && phase_reg) begin
            acc_reg <= acc_next;
            unique case (st.dst)
                etmm_pkg::DS_SASB: sasb_reg  <= acc_next[OPW-1:0];
                etmm_pkg::DS_CASB: casb_reg  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R00:  r_reg[0]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R01:  r_reg[1]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R02:  r_reg[2]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R10:  r_reg[3]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R11:  r_reg[4]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R12:  r_reg[5]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R20:  r_reg[6]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R21:  r_reg[7]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_R22:  r_reg[8]  <= acc_next[OPW-1:0];
                etmm_pkg::DS_M00:  m_reg[0]  <= acc_sat;
                etmm_pkg::DS_M01:  m_reg[1]  <= acc_sat;
                etmm_pkg::DS_M02:  m_reg[2]  <= acc_sat;
                etmm_pkg::DS_M10:  m_reg[3]  <= acc_sat;
                etmm_pkg::DS_M11:  m_reg[4]  <= acc_sat;
                etmm_pkg::DS_M12:  m_reg[5]  <= acc_sat;
                etmm_pkg::DS_M20:  m_reg[6]  <= acc_sat;
                etmm_pkg::DS_M21:  m_reg[7]  <= acc_sat;
                etmm_pkg::DS_M22:  m_reg[8]  <= acc_sat;
                etmm_pkg::DS_C30:  c3_reg[0] <= acc_sat;
                etmm_pkg::DS_C31:  c3_reg[1] <= acc_sat;
                etmm_pkg::DS_C32:  c3_reg[2] <= acc_sat;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_row0 = '0;
        m_row1 = '0;
        m_row2 = '0;
        m_row3 = '0;
        unique case (col_reg)
            2'd0: begin m_row0 = m_reg[0]; m_row1 = m_reg[3]; m_row2 = m_reg[6]; end
            2'd1: begin m_row0 = m_reg[1]; m_row1 = m_reg[4]; m_row2 = m_reg[7]; end
            2'd2: begin m_row0 = m_reg[2]; m_row1 = m_reg[5]; m_row2 = m_reg[8]; end
            default: begin
                m_row3 = ONE_FX;
                unique case (item_reg.kind)
                    etmm_pkg::TX_LOCAL: begin
                        m_row0 = c3_reg[0];
                        m_row1 = c3_reg[1];
                        m_row2 = c3_reg[2];
                    end
                    etmm_pkg::TX_GLOBAL: begin
                        m_row0 = item_reg.tx;
                        m_row1 = item_reg.ty;
                        m_row2 = item_reg.tz;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_column_index = col_reg;
    assign m_last_column  = (col_reg == 2'd3);

endmodule

### hdl/euler_trs_model_matrix.sv
`timescale 1ns / 1ps
// Top level of the Euler-angle TRS model matrix builder: front end queue and back end.
// Depends on etmm_pkg, etmm_front and etmm_back.
//
//   Channel   Direction   Handshake          Carries
//   s_        in          s_valid/s_ready    one transform request word
//   m_        out         m_valid/m_ready    one matrix column word, four per request
//
// A request is taken from the queue and passes through the three parallel trig units
// (iterations capped at 30), then through the 33 steps of the one shared multiplier,
// each a multiply phase then an accumulate phase. Its four columns then leave one a cycle
// while m_ready is high. The two-entry front queue keeps taking requests while the back
// end works. Reset is synchronous and clears control only.

module euler_trs_model_matrix #(
    parameter int FRAC_BITS       = etmm_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = etmm_pkg::TRIG_ITER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_trans_x,
    input  logic signed [31:0] s_trans_y,
    input  logic signed [31:0] s_trans_z,
    input  logic signed [31:0] s_angle_x,
    input  logic signed [31:0] s_angle_y,
    input  logic signed [31:0] s_angle_z,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    input  logic signed [31:0] s_scale_z,
    input  logic [1:0]         s_translate_mode,
    input  logic               s_rotate_enable,
    input  logic               s_scale_enable,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_column_index,
    output logic signed [31:0] m_row0,
    output logic signed [31:0] m_row1,
    output logic signed [31:0] m_row2,
    output logic signed [31:0] m_row3,
    output logic               m_last_column
);

    logic            q_valid;
    logic            q_pop;
    etmm_pkg::item_t q_item;

    etmm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_trans_x(s_trans_x), .s_trans_y(s_trans_y), .s_trans_z(s_trans_z),
        .s_angle_x(s_angle_x), .s_angle_y(s_angle_y), .s_angle_z(s_angle_z),
        .s_scale_x(s_scale_x), .s_scale_y(s_scale_y), .s_scale_z(s_scale_z),
        .s_translate_mode(s_translate_mode), .s_rotate_enable(s_rotate_enable),
        .s_scale_enable(s_scale_enable),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    etmm_back #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_column_index(m_column_index),
        .m_row0(m_row0), .m_row1(m_row1), .m_row2(m_row2), .m_row3(m_row3),
        .m_last_column(m_last_column)
    );

endmodule

### hdl/etmm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the model matrix builder and its bind to the top level.
// Depends only on the top level's ports.

module etmm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_column_index,
    input logic signed [31:0] m_row0,
    input logic signed [31:0] m_row3,
    input logic               m_last_column
);

    // The last flag marks column 3 and nothing else.
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_column == (m_column_index == 2'd3)))
        else $error("last_column does not match column 3");

    // Columns of one matrix follow each other without a gap.
    a_next_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_column) |=>
            (m_valid && (m_column_index == $past(m_column_index) + 2'd1)))
        else $error("column sequence broken");

    // The bottom row is zero in the first three columns.
    a_bottom_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_column_index != 2'd3)) |-> (m_row3 == 32'sd0))
        else $error("bottom row nonzero in a linear column");

    // A stalled column word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row0) && $stable(m_column_index)))
        else $error("stalled column word changed");

endmodule

bind euler_trs_model_matrix etmm_checker u_etmm_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_column_index(m_column_index), .m_row0(m_row0), .m_row3(m_row3),
    .m_last_column(m_last_column)
);

### dv/tb_euler_trs_model_matrix.sv
`timescale 1ns / 1ps
// Self-checking testbench for euler_trs_model_matrix: directed table, then random requests,
// each checked column by column against a fixed-point model held here. Depends on etmm_pkg and euler_trs_model_matrix.

module tb_euler_trs_model_matrix;

    localparam int FB = 16;
    localparam int ITERS = 16;
    localparam int NUM_RANDOM = 300;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 1500;
    localparam logic [1:0] TMODE_SPARE = 2'd3;

    typedef struct {
        logic signed [31:0] t [3];
        logic signed [31:0] a [3];
        logic signed [31:0] s [3];
        logic [1:0]         mode;
        logic               rot;
        logic               scl;
        logic               ident;
    } request_t;

    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] row [4];
        logic               last;
    } column_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_trans_x, s_trans_y, s_trans_z;
    logic signed [31:0] s_angle_x, s_angle_y, s_angle_z;
    logic signed [31:0] s_scale_x, s_scale_y, s_scale_z;
    logic [1:0]         s_translate_mode;
    logic               s_rotate_enable;
    logic               s_scale_enable;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_column_index;
    logic signed [31:0] m_row0, m_row1, m_row2, m_row3;
    logic               m_last_column;

    column_t  pending_columns [$];
    longint   atan_lut [etmm_pkg::ATAN_SLOTS];
    int       errors;
    int       idle_cycles;
    int       columns_seen;
    bit       held_once;
    request_t directed [$];

    euler_trs_model_matrix DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint div_frac(longint num, longint den, int bits);
        longint q;
        q = 0;
        for (int k = 0; k < bits; k++) begin
            num = num << 1;
            q = q << 1;
            if (num >= den) begin
                num = num - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic void fill_atan_lut();
        longint sum;
        longint term;
        int e;
        atan_lut[0] = longint'(1) << (etmm_pkg::QUAD_BITS - 1);
        for (int i = 1; i < etmm_pkg::ATAN_SLOTS; i++) begin
            sum = 0;
            for (int k = 0; i * (2 * k + 1) <= etmm_pkg::SERIES_BITS; k++) begin
                e = i * (2 * k + 1);
                term = (longint'(1) << (etmm_pkg::SERIES_BITS - e)) / longint'(2 * k + 1);
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            atan_lut[i] = div_frac(sum, longint'(etmm_pkg::PI_SERIES),
                                   etmm_pkg::QUAD_BITS + 1);
        end
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rmul30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic void sin_cos_deg(longint ang, output longint c, output longint s);
        longint full, quarter, r, q, rem, x, y, z, xs, ys;
        full = longint'(360) << FB;
        quarter = longint'(90) << FB;
        r = ang % full;
        if (r < 0) r += full;
        q = r / quarter;
        rem = r - q * quarter;
        z = (rem << (etmm_pkg::QUAD_BITS - FB)) / 90;
        x = etmm_pkg::GAIN_Q30;
        y = 0;
        for (int i = 0; i < ITERS && i < etmm_pkg::ATAN_SLOTS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_lut[i];
            end else begin
                x += ys; y -= xs; z += atan_lut[i];
            end
        end
        case (q % 4)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic void queue_model_columns(request_t rq);
        longint rm [3][3];
        longint sc [3];
        longint mat [4][4];
        longint ca, sa, cb, sb, cz, sz, acc;
        column_t col;
        for (int i = 0; i < 3; i++) begin
            sc[i] = rq.scl ? longint'(rq.s[i]) : (longint'(1) << FB);
            for (int j = 0; j < 3; j++) rm[i][j] = (i == j) ? (longint'(1) << 30) : 0;
        end
        if (rq.rot) begin
            sin_cos_deg(rq.a[0], ca, sa);
            sin_cos_deg(rq.a[1], cb, sb);
            sin_cos_deg(rq.a[2], cz, sz);
            rm[0][0] = rmul30(cb, cz);
            rm[0][1] = rmul30(cb, sz);
            rm[0][2] = sb;
            rm[1][0] = rmul30(rmul30(sa, sb), cz) - rmul30(ca, sz);
            rm[1][1] = rmul30(rmul30(sa, sb), sz) + rmul30(ca, cz);
            rm[1][2] = -rmul30(sa, cb);
            rm[2][0] = -rmul30(rmul30(ca, sb), cz) - rmul30(sa, sz);
            rm[2][1] = -rmul30(rmul30(ca, sb), sz) + rmul30(sa, cz);
            rm[2][2] = rmul30(ca, cb);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                mat[i][j] = clamp32((rm[i][j] * sc[j] + (longint'(1) << 29)) >>> 30);
            mat[3][i] = 0;
        end
        mat[3][3] = longint'(1) << FB;
        for (int i = 0; i < 3; i++) begin
            if (rq.mode == etmm_pkg::TMODE_LOCAL) begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += (mat[i][j] * longint'(rq.t[j]) + (longint'(1) << (FB - 1))) >>> FB;
                mat[i][3] = clamp32(acc);
            end else if (rq.mode == etmm_pkg::TMODE_GLOBAL) begin
                mat[i][3] = rq.t[i];
            end else begin
                mat[i][3] = 0;
            end
        end
        for (int j = 0; j < 4; j++) begin
            col.idx = 2'(j);
            for (int i = 0; i < 4; i++) col.row[i] = 32'(mat[i][j]);
            col.last = (j == 3);
            pending_columns.push_back(col);
        end
    endfunction

    function automatic void queue_identity_columns(request_t rq);
        column_t col;
        for (int j = 0; j < 4; j++) begin
            col.idx = 2'(j);
            for (int i = 0; i < 4; i++) col.row[i] = (i == j) ? 32'sh0001_0000 : 32'sh0;
            if (j == 3 && rq.mode == etmm_pkg::TMODE_GLOBAL)
                for (int i = 0; i < 3; i++) col.row[i] = rq.t[i];
            col.last = (j == 3);
            pending_columns.push_back(col);
        end
    endfunction

    function automatic request_t make_request(int tx, int ty, int tz, int ax, int ay, int az,
                                              int sx, int sy, int sz, logic [1:0] mode,
                                              logic rot, logic scl, logic ident);
        request_t rq;
        rq.t = '{tx, ty, tz};
        rq.a = '{ax, ay, az};
        rq.s = '{sx, sy, sz};
        rq.mode = mode;
        rq.rot = rot;
        rq.scl = scl;
        rq.ident = ident;
        return rq;
    endfunction

    function automatic logic signed [31:0] pick_value(int small_range);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 2 * small_range)) - small_range;
        endcase
    endfunction

    function automatic request_t random_request();
        request_t rq;
        for (int i = 0; i < 3; i++) begin
            rq.t[i] = pick_value(32'h0040_0000);
            rq.a[i] = $urandom_range(0, 4) == 0 ? 32'(($urandom_range(0, 8) * 45) << FB)
                                                : pick_value(32'h02D0_0000);
            rq.s[i] = pick_value(32'h0004_0000);
        end
        rq.mode = 2'($urandom_range(0, 3));
        rq.rot = $urandom_range(0, 3) != 0;
        rq.scl = $urandom_range(0, 2) != 0;
        rq.ident = 1'b0;
        return rq;
    endfunction

    task automatic send_request(request_t rq);
        int gap;
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_trans_x <= rq.t[0]; s_trans_y <= rq.t[1]; s_trans_z <= rq.t[2];
        s_angle_x <= rq.a[0]; s_angle_y <= rq.a[1]; s_angle_z <= rq.a[2];
        s_scale_x <= rq.s[0]; s_scale_y <= rq.s[1]; s_scale_z <= rq.s[2];
        s_translate_mode <= rq.mode;
        s_rotate_enable <= rq.rot;
        s_scale_enable <= rq.scl;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (rq.ident) queue_identity_columns(rq);
        else queue_model_columns(rq);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        {s_trans_x, s_trans_y, s_trans_z, s_angle_x, s_angle_y, s_angle_z} = '0;
        {s_scale_x, s_scale_y, s_scale_z} = '0;
        s_translate_mode = etmm_pkg::TMODE_NONE;
        s_rotate_enable = 1'b0;
        s_scale_enable = 1'b0;
        errors = 0;
        fill_atan_lut();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0,
            etmm_pkg::TMODE_NONE, 0, 0, 1));
        directed.push_back(make_request(32'h7FFFFFFF, 32'h80000000, 32'h00010000,
            0, 0, 0, 0, 0, 0, etmm_pkg::TMODE_GLOBAL, 0, 0, 1));
        directed.push_back(make_request(-1, 5, 7, 0, 0, 0, 0, 0, 0, TMODE_SPARE, 0, 0, 1));
        directed.push_back(make_request(3 << 16, -2 << 16, 1 << 16,
            0, 0, 0, 0, 0, 0, etmm_pkg::TMODE_LOCAL, 0, 0, 0));
        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16,
            etmm_pkg::TMODE_NONE, 1, 1, 0));
        directed.push_back(make_request(1 << 16, 2 << 16, 3 << 16, 90 << 16, 180 << 16,
            270 << 16, 1 << 16, 1 << 16, 1 << 16, etmm_pkg::TMODE_LOCAL, 1, 0, 0));
        directed.push_back(make_request(0, 0, 0, -(90 << 16), 360 << 16, 45 << 16,
            0, 0, 0, etmm_pkg::TMODE_GLOBAL, 1, 0, 0));
        directed.push_back(make_request(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
            0, 0, 0, etmm_pkg::TMODE_NONE, 1, 0, 0));
        directed.push_back(make_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, etmm_pkg::TMODE_LOCAL, 0, 1, 0));
        directed.push_back(make_request(32'h80000000, 32'h80000000, 32'h80000000,
            30 << 16, 60 << 16, -(135 << 16), 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
            etmm_pkg::TMODE_LOCAL, 1, 1, 0));
        directed.push_back(make_request(1, -1, 1, 1, -1, 1, -1, 1, -1,
            etmm_pkg::TMODE_LOCAL, 1, 1, 0));
        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0,
            etmm_pkg::TMODE_LOCAL, 1, 1, 0));
        directed.push_back(make_request(5 << 16, 6 << 16, 7 << 16, 720 << 16, -(720 << 16),
            (89 << 16) + 32'hFFFF, 2 << 16, 3 << 16, 4 << 16,
            etmm_pkg::TMODE_GLOBAL, 1, 1, 0));

        foreach (directed[k]) send_request(directed[k]);
        for (int k = 0; k < NUM_RANDOM; k++) send_request(random_request());
        s_valid <= 1'b0;

        while (pending_columns.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        column_t want;
        int gap;
        columns_seen = 0;
        held_once = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held_once && columns_seen >= 40) begin
                held_once = 1'b1;
                gap = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            columns_seen++;
            if (pending_columns.size() == 0) begin
                errors++;
                $display("%0t: unexpected column word, actual idx=%0d", $time, m_column_index);
            end else begin
                want = pending_columns.pop_front();
                if (m_column_index !== want.idx || m_last_column !== want.last ||
                    m_row0 !== want.row[0] || m_row1 !== want.row[1] ||
                    m_row2 !== want.row[2] || m_row3 !== want.row[3]) begin
                    errors++;
                    $display("%0t: mismatch expected idx=%0d rows=%h %h %h %h last=%b",
                             $time, want.idx, want.row[0], want.row[1], want.row[2],
                             want.row[3], want.last);
                    $display("%0t:          actual   idx=%0d rows=%h %h %h %h last=%b",
                             $time, m_column_index, m_row0, m_row1, m_row2, m_row3,
                             m_last_column);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
